>>> rtl/core/ifla_pkg.sv
// ----------------------------------------------------------------------------
// ifla_pkg: shared types and constants for the index free-list allocator
// Slot and link widths, command codes, channel words and the update bundle.
// ----------------------------------------------------------------------------
package ifla_pkg;

	localparam int ADDR_W    = 8;
	localparam int ENTRY_CNT = 1 << ADDR_W;
	localparam int LINK_W    = ADDR_W + 1;

	typedef enum logic {
		CMD_POP  = 1'b0,
		CMD_PUSH = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] slot_index;
	} cmd_word_t;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] given_index;
	} rsp_word_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		link_wr_t          wr;
		logic [LINK_W-1:0] head_next;
		logic              ok;
		logic [ADDR_W-1:0] given;
	} exec_upd_t;

endpackage

>>> rtl/core/ifla_link_store.sv
// ----------------------------------------------------------------------------
// ifla_link_store: per-slot link words
// Link memory with registered read, per-entry valid bits and write forwarding.
// ----------------------------------------------------------------------------
module ifla_link_store
	import ifla_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rebuild,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  link_wr_t          wr,
	output logic [LINK_W-1:0] link
);

	logic [LINK_W-1:0]    mem [ENTRY_CNT];
	logic [ENTRY_CNT-1:0] valid_q;
	logic [LINK_W-1:0]    rd_data_q;
	logic                 rd_valid_q;
	logic [ADDR_W-1:0]    rd_addr_q;
	logic                 fwd_hit_q;
	logic [LINK_W-1:0]    fwd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			rd_addr_q  <= rd_addr;
			fwd_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			fwd_hit_q  <= 1'b0;
		end else begin
			if (rebuild) begin
				valid_q <= '0;
			end else if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
				fwd_hit_q  <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	// untouched entries read as their reset link, slot plus one
	always_comb begin
		if (fwd_hit_q) begin
			link = fwd_data_q;
		end else if (rd_valid_q) begin
			link = rd_data_q;
		end else begin
			link = {1'b0, rd_addr_q} + LINK_W'(1);
		end
	end

endmodule

>>> rtl/core/ifla_exec.sv
// ----------------------------------------------------------------------------
// ifla_exec: command evaluation
// Decide pop or push outcome, the link write and the next head.
// ----------------------------------------------------------------------------
module ifla_exec
	import ifla_pkg::*;
(
	input  logic              active,
	input  cmd_word_t         item,
	input  logic [LINK_W-1:0] head,
	input  logic [LINK_W-1:0] entries,
	input  logic [LINK_W-1:0] link,
	output exec_upd_t         upd
);

	logic [LINK_W-1:0] marker;
	logic              pop_ok;
	logic              push_ok;

	assign marker  = entries + LINK_W'(1);
	assign pop_ok  = head < entries;
	// refuse out-of-range slots and slots not currently handed out
	assign push_ok = ({1'b0, item.slot_index} < entries) && (link == marker);

	always_comb begin
		upd.head_next = head;
		unique case (item.cmd)
			CMD_POP: begin
				upd.ok      = pop_ok;
				upd.given   = pop_ok ? head[ADDR_W-1:0] : '0;
				upd.wr.addr = head[ADDR_W-1:0];
				upd.wr.data = marker;
				if (active && pop_ok) begin
					upd.head_next = link;
				end
			end
			CMD_PUSH: begin
				upd.ok      = push_ok;
				upd.given   = '0;
				upd.wr.addr = item.slot_index;
				upd.wr.data = head;
				if (active && push_ok) begin
					upd.head_next = {1'b0, item.slot_index};
				end
			end
			default: begin
				upd.ok      = 1'b0;
				upd.given   = '0;
				upd.wr.addr = '0;
				upd.wr.data = '0;
			end
		endcase
		upd.wr.en = active && upd.ok;
	end

endmodule

>>> rtl/core/index_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// index_free_list_allocator_top: slot index allocator on a linked free list
// Pop hands out the head slot, push returns a handed-out slot to the head.
// ----------------------------------------------------------------------------
// Every command word yields exactly one response word. A command can be taken
// every clock cycle while the response side is not stalled. The accepting
// edge loads stage 1 and performs the link read; the response register is
// loaded when stage 1 retires. The throughput of one word per cycle
// is set by the link memory read port: the read address of the next command
// is formed from the head that the current command produces, and a link
// written in the same cycle is forwarded to the following read. After reset,
// or after a write of entries_in_use, every link reads as its slot number
// plus one through per-entry valid bits, so no clearing pass is needed and
// commands are taken at once. A written entries_in_use of 0 is stored as 1,
// and a value above 256 as 256. Write the register only while no command is
// outstanding.
module index_free_list_allocator_top
	import ifla_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cmd_word_t         cmd_word,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_word_t         rsp_word,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LINK_W-1:0] cfg_data
);

	logic              entries_q;
	logic [LINK_W-1:0] entries_cnt_q;
	logic [LINK_W-1:0] entries_clamped;
	logic [LINK_W-1:0] head_q;
	logic              item_valid_s1;
	cmd_word_t         item_s1;
	logic              rsp_valid_q;
	rsp_word_t         rsp_word_q;
	logic              cfg_fire;
	logic              cmd_fire;
	logic              s1_fire;
	logic [ADDR_W-1:0] rd_addr;
	logic [LINK_W-1:0] link;
	exec_upd_t         upd;

	// config is always taken; it must arrive while the pipe is empty
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	// stage 1 retires when the response register is free or being drained
	assign s1_fire   = item_valid_s1 && !(rsp_valid_q && rsp_stall);
	assign cmd_stall = item_valid_s1 && !s1_fire;
	assign cmd_fire  = cmd_valid && !cmd_stall;

	// clamp the written slot count into 1..ENTRY_CNT
	always_comb begin
		if (cfg_data == '0) begin
			entries_clamped = LINK_W'(1);
		end else if (cfg_data > LINK_W'(ENTRY_CNT)) begin
			entries_clamped = LINK_W'(ENTRY_CNT);
		end else begin
			entries_clamped = cfg_data;
		end
	end

	// flag tracks that the slot count register has been written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q     <= 1'b0;
			entries_cnt_q <= LINK_W'(ENTRY_CNT);
		end else if (cfg_fire) begin
			entries_q     <= 1'b1;
			entries_cnt_q <= entries_clamped;
		end
	end

	// next command reads the link at its own slot (push) or at the head that
	// the retiring command leaves behind (pop)
	assign rd_addr = (cmd_word.cmd == CMD_PUSH) ? cmd_word.slot_index
	                                            : upd.head_next[ADDR_W-1:0];

	ifla_link_store u_link_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rebuild (cfg_fire),
		.rd_en   (cmd_fire),
		.rd_addr (rd_addr),
		.wr      (upd.wr),
		.link    (link)
	);

	ifla_exec u_exec (
		.active  (s1_fire),
		.item    (item_s1),
		.head    (head_q),
		.entries (entries_cnt_q),
		.link    (link),
		.upd     (upd)
	);

	// head register: a config write rebuilds the list and restarts at slot 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (cfg_fire) begin
			head_q <= '0;
		end else begin
			head_q <= upd.head_next;
		end
	end

	// stage 1: hold the command while its link read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (cmd_fire) begin
			item_valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			item_s1 <= cmd_word;
		end
	end

	// response register: load on retire, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rsp_word_q.ok          <= upd.ok;
			rsp_word_q.given_index <= upd.given;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

`ifndef ASSERT_OFF
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LINK_W'(ENTRY_CNT))
		else $error("free head beyond slot range");

	a_entries_range: assert property (@(posedge clk) disable iff (!arst_n)
		entries_q |-> (entries_cnt_q != '0) && (entries_cnt_q <= LINK_W'(ENTRY_CNT)))
		else $error("slot count outside clamp range");

	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> head_q == '0)
		else $error("config write did not restart the free list");

	a_retire_loads_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp_valid)
		else $error("retired command produced no response");

	a_fail_no_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_word.ok |-> rsp_word.given_index == '0)
		else $error("failed command carries a slot index");

	a_stall_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> item_valid_s1 && rsp_valid && rsp_stall)
		else $error("command stalled with a free pipeline");
`endif

endmodule

>>> bench/index_free_list_allocator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// index_free_list_allocator_top_test: self-checking bench for the slot allocator
// Offers pop and push command words in random bursts, stalls the response side
// on shifting patterns and rewrites entries_in_use between phases. Every
// response word is checked against its typed-in value or the in-bench free-list model.
// ----------------------------------------------------------------------------
module index_free_list_allocator_top_test;
	import ifla_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 5;
	localparam int CFG_SETTLE      = 4;
	localparam int DRAIN_CYCLES    = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int REPORT_LIMIT    = 10;

	typedef enum bit { ROW_CMD, ROW_CFG } row_kind_t;

	typedef enum int { STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC } stall_mode_t;

	// One row of the directed table. For commands, value carries the slot index;
	// for register writes it carries the raw entries_in_use data. The response
	// is typed in only where fixed is set, otherwise the free-list model decides.
	typedef struct packed {
		row_kind_t         kind;
		cmd_t              cmd;
		logic [LINK_W-1:0] value;
		bit                fixed;
		rsp_word_t         rsp;
	} dir_row_t;

	// One random phase: register setting (drawn from entries..rand_hi when
	// rand_hi is nonzero), number of command words, share of pops, and whether
	// the receiver holds off for a long stretch during the phase.
	typedef struct packed {
		logic [LINK_W-1:0] entries;
		logic [LINK_W-1:0] rand_hi;
		logic [10:0]       items;
		logic [6:0]        pop_pct;
		bit                squeeze;
	} phase_t;

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_stall;
	cmd_word_t         cmd_word;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_word_t         rsp_word;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LINK_W-1:0] cfg_data;

	// Free-list model state, kept in step with every accepted word.
	logic [LINK_W-1:0] model_entries;
	logic [LINK_W-1:0] model_head;
	logic [LINK_W-1:0] model_links [ENTRY_CNT];
	logic [ADDR_W-1:0] held_slots [$];      // slots currently handed out

	rsp_word_t         rsp_expect_q [$];    // responses still owed, oldest first
	rsp_word_t         oldest_rsp;
	int                mismatch_cnt = 0;
	int                burst_left   = 0;
	bit                hold_off_req = 1'b0;

	// Directed walk: double free right after reset, pop/push round trips,
	// the one-slot list running empty, out-of-range pushes, and register
	// writes of 0, 511 and 257 that must clamp to 1, 256 and 256.
	dir_row_t dir_rows [25] = '{
		'{ROW_CMD, CMD_PUSH, 9'd0,   1'b1, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd255, 1'b1, '{1'b1, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd0,   1'b1, '{1'b1, 8'd1}},
		'{ROW_CMD, CMD_PUSH, 9'd0,   1'b1, '{1'b1, 8'd0}},
		'{ROW_CMD, CMD_PUSH, 9'd0,   1'b1, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd170, 1'b1, '{1'b1, 8'd0}},
		'{ROW_CMD, CMD_PUSH, 9'd255, 1'b1, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_PUSH, 9'd1,   1'b0, '{1'b0, 8'd0}},
		'{ROW_CFG, CMD_POP,  9'd0,   1'b0, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd85,  1'b1, '{1'b1, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd0,   1'b1, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_PUSH, 9'd1,   1'b1, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_PUSH, 9'd255, 1'b1, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_PUSH, 9'd0,   1'b1, '{1'b1, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd0,   1'b1, '{1'b1, 8'd0}},
		'{ROW_CFG, CMD_POP,  9'd511, 1'b0, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd0,   1'b1, '{1'b1, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd0,   1'b0, '{1'b0, 8'd0}},
		'{ROW_CFG, CMD_POP,  9'd257, 1'b0, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_PUSH, 9'd0,   1'b1, '{1'b0, 8'd0}},
		'{ROW_CFG, CMD_POP,  9'd2,   1'b0, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd0,   1'b1, '{1'b1, 8'd0}},
		'{ROW_CMD, CMD_POP,  9'd0,   1'b1, '{1'b1, 8'd1}},
		'{ROW_CMD, CMD_POP,  9'd0,   1'b1, '{1'b0, 8'd0}},
		'{ROW_CMD, CMD_PUSH, 9'd1,   1'b0, '{1'b0, 8'd0}}
	};

	// Small lists dominate so the empty and out-of-range cases come often;
	// the 511 phase is pop-heavy and long enough to hand out every slot.
	phase_t phases [12] = '{
		'{9'd256, 9'd0,   11'd90,  7'd50, 1'b0},
		'{9'd1,   9'd0,   11'd60,  7'd50, 1'b0},
		'{9'd0,   9'd0,   11'd60,  7'd45, 1'b0},
		'{9'd511, 9'd0,   11'd330, 7'd95, 1'b0},
		'{9'd2,   9'd0,   11'd70,  7'd50, 1'b0},
		'{9'd3,   9'd0,   11'd70,  7'd55, 1'b0},
		'{9'd257, 9'd0,   11'd100, 7'd60, 1'b1},
		'{9'd16,  9'd0,   11'd90,  7'd55, 1'b0},
		'{9'd0,   9'd511, 11'd90,  7'd50, 1'b0},
		'{9'd255, 9'd0,   11'd60,  7'd70, 1'b0},
		'{9'd1,   9'd8,   11'd70,  7'd50, 1'b0},
		'{9'd4,   9'd0,   11'd60,  7'd45, 1'b0}
	};

	index_free_list_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Clamp the register value, then rebuild the list: link i -> i+1, head 0.
	function automatic void model_load_entries(logic [LINK_W-1:0] value);
		logic [LINK_W-1:0] n;
		n = value;
		if (n == '0)
			n = LINK_W'(1);
		if (n > LINK_W'(ENTRY_CNT))
			n = LINK_W'(ENTRY_CNT);
		model_entries = n;
		for (int i = 0; i < ENTRY_CNT; i++)
			model_links[i] = LINK_W'(i + 1);
		model_head = '0;
		held_slots.delete();
	endfunction

	// Apply one command word to the model and return the response it owes.
	// A handed-out slot carries entries+1 in its link; that is what a push
	// must find, or it is refused as a double free.
	function automatic rsp_word_t alloc_predict(cmd_word_t w);
		rsp_word_t         r;
		logic [LINK_W-1:0] marker;
		logic [ADDR_W-1:0] taken;
		r      = '0;
		marker = model_entries + 1'b1;
		if (w.cmd == CMD_POP) begin
			if (model_head < model_entries) begin
				taken              = model_head[ADDR_W-1:0];
				model_head         = model_links[taken];
				model_links[taken] = marker;
				r.ok               = 1'b1;
				r.given_index      = taken;
				held_slots.push_back(taken);
			end
		end else if (LINK_W'(w.slot_index) < model_entries &&
				model_links[w.slot_index] == marker) begin
			model_links[w.slot_index] = model_head;
			model_head                = LINK_W'(w.slot_index);
			r.ok                      = 1'b1;
			for (int i = 0; i < held_slots.size(); i++)
				if (held_slots[i] == w.slot_index) begin
					held_slots.delete(i);
					break;
				end
		end
		return r;
	endfunction

	// Offer one command word and hold it until accepted. Pacing: bursts of
	// random length, each opened by a random gap, with an occasional long
	// burst and no gap at all. Valid stays high across back-to-back words.
	task automatic issue_cmd(cmd_word_t w, bit fixed, rsp_word_t typed_rsp);
		rsp_word_t predicted;
		int        gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(40, 80);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 20);
				gap        = $urandom_range(0, 6);
			end
			if (gap > 0) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		do
			@(posedge clk);
		while (cmd_stall);
		predicted = alloc_predict(w);
		rsp_expect_q.push_back(fixed ? typed_rsp : predicted);
	endtask

	// Write entries_in_use only with the block idle: drop valid, wait for
	// every owed response, let the pipeline settle, then do the handshake.
	task automatic write_entries(logic [LINK_W-1:0] value);
		@(negedge clk);
		cmd_valid <= 1'b0;
		burst_left = 0;
		while (rsp_expect_q.size() != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		model_load_entries(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Receiver: switch among stall patterns in spans of random length. When
	// the sender asks for it, hold off for a long stretch so the block fills
	// up and pushes back on the command side.
	initial begin
		stall_mode_t mode;
		int          span;
		int          period;
		rsp_stall = 1'b0;
		forever begin
			mode   = stall_mode_t'($urandom_range(0, 3));
			span   = $urandom_range(16, 160);
			period = $urandom_range(2, 8);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_off_req) begin
					rsp_stall <= 1'b1;
					repeat (HOLD_OFF_CYCLES) @(negedge clk);
					hold_off_req = 1'b0;
				end else begin
					case (mode)
						STALL_NONE:  rsp_stall <= 1'b0;
						STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
						STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
						default:     rsp_stall <= ((k % period) < (period / 2));
					endcase
				end
			end
		end
	end

	// Response checker: compare each accepted word, field by field, with the
	// oldest owed response. Report the first few failures, count the rest.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expect_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= REPORT_LIMIT)
					$display("%0t: response word with none owed: ok=%0b index=%0d",
						$time, rsp_word.ok, rsp_word.given_index);
			end else begin
				oldest_rsp = rsp_expect_q.pop_front();
				if (rsp_word.ok !== oldest_rsp.ok ||
						rsp_word.given_index !== oldest_rsp.given_index) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_LIMIT)
						$display("%0t: response mismatch: expected ok=%0b index=%0d, got ok=%0b index=%0d",
							$time, oldest_rsp.ok, oldest_rsp.given_index,
							rsp_word.ok, rsp_word.given_index);
				end
			end
		end
	end

	// Watchdog: end the run if no handshake completes for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("** index_free_list_allocator_top: FAILED **");
		$finish;
	end

	// Main sequence: reset, directed table, random phases, drain, verdict.
	initial begin
		cmd_word_t         w;
		phase_t            ph;
		logic [LINK_W-1:0] cfg_val;
		int                roll;
		int                n;

		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_word  = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		model_load_entries(LINK_W'(ENTRY_CNT));
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				write_entries(dir_rows[i].value);
			end else begin
				w.cmd        = dir_rows[i].cmd;
				w.slot_index = dir_rows[i].value[ADDR_W-1:0];
				issue_cmd(w, dir_rows[i].fixed, dir_rows[i].rsp);
			end
		end

		// Random part: mostly pops and pushes of slots really handed out, the
		// rest pushes of arbitrary slots (double frees, out of range). The pop
		// slot field is random too, since the block must ignore it.
		foreach (phases[p]) begin
			ph      = phases[p];
			cfg_val = (ph.rand_hi != 0) ?
				LINK_W'($urandom_range(ph.entries, ph.rand_hi)) : ph.entries;
			write_entries(cfg_val);
			for (n = 0; n < ph.items; n++) begin
				if (ph.squeeze && n == 10)
					hold_off_req = 1'b1;
				roll         = $urandom_range(0, 99);
				w.slot_index = ADDR_W'($urandom_range(0, ENTRY_CNT - 1));
				if (roll < ph.pop_pct) begin
					w.cmd = CMD_POP;
				end else begin
					w.cmd = CMD_PUSH;
					if ($urandom_range(0, 9) < 8 && held_slots.size() != 0)
						w.slot_index = held_slots[$urandom_range(0, held_slots.size() - 1)];
				end
				issue_cmd(w, 1'b0, '0);
			end
		end

		// Drain: drop valid, wait for every owed response, then idle a little
		// longer so a stray extra word would still be caught.
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (rsp_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (rsp_expect_q.size() != 0)
			mismatch_cnt++;

		if (mismatch_cnt == 0)
			$display("** index_free_list_allocator_top: PASSED **");
		else
			$display("** index_free_list_allocator_top: FAILED **");
		$finish;
	end

endmodule

>>> files.f
rtl/core/ifla_pkg.sv
rtl/core/ifla_link_store.sv
rtl/core/ifla_exec.sv
rtl/core/index_free_list_allocator_top.sv
bench/index_free_list_allocator_top_test.sv
